>>> rtl/core/pipb_pkg.sv
// shared types and constants for the point-in-polygon boundary classifier
`default_nettype none
package pipb_pkg;

  localparam int TOL_WIDTH     = 31;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int MUL_DIGIT     = 16;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_QUERY_X   = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_QUERY_Y   = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TOLERANCE = 2'd2;

  localparam logic [1:0] LOC_OUTSIDE  = 2'd0;
  localparam logic [1:0] LOC_INSIDE   = 2'd1;
  localparam logic [1:0] LOC_BOUNDARY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ISSUE,
    S_MUL,
    S_DUP_EVAL,
    S_EDGE_EVAL,
    S_FINISH
  } ctl_state_t;

  typedef enum logic [3:0] {
    MOP_E2,
    MOP_LEN_A,
    MOP_LEN_B,
    MOP_DOT_A,
    MOP_DOT_B,
    MOP_CR_A,
    MOP_CR_B,
    MOP_DA_A,
    MOP_DA_B,
    MOP_DB_A,
    MOP_DB_B,
    MOP_CSQ,
    MOP_ELEN
  } mop_t;

  typedef enum logic {
    PH_DUP,
    PH_EDGE
  } phase_t;

  typedef enum logic [1:0] {
    AB_FIRST_VTX,
    AB_PREV_VTX,
    AB_PREV_FIRST,
    AB_VTX_FIRST
  } ab_sel_t;

  typedef struct packed {
    logic    take_vertex;
    logic    set_first;
    logic    load_ab;
    ab_sel_t ab_sel;
    logic    mul_start;
    mop_t    mop;
    logic    edge_done;
    logic    use_perp;
    logic    set_prev;
    logic    clear_ring;
  } pipb_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic len_zero;
    logic dot_pos;
    logic far_end;
    logic near_pt;
    logic near_dup;
    logic near_perp;
    logic parity;
    logic boundary;
  } pipb_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/pipb_if.sv
// item channel interfaces for vertices in and classification results out
`default_nettype none
interface pipb_in_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          is_last;
  modport source (output valid, output vertex_x, output vertex_y, output is_last,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input is_last,
                output ready);
endinterface

interface pipb_out_if #(parameter int COUNT_WIDTH = 16);
  logic                   valid;
  logic                   ready;
  logic [1:0]             location;
  logic [COUNT_WIDTH-1:0] effective_count;
  modport source (output valid, output location, output effective_count, input ready);
  modport sink (input valid, input location, input effective_count, output ready);
endinterface
`default_nettype wire

>>> rtl/core/pipb_mul.sv
// iterative signed multiplier, one 16-bit digit of the multiplier per cycle
`default_nettype none
module pipb_mul #(
  parameter int OPW = 67
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [OPW-1:0] a_i,
  input  logic signed [OPW-1:0] b_i,
  output logic                  done,
  output logic [2*OPW-1:0]      prod
);
  import pipb_pkg::*;

  localparam int CH   = (OPW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int BW   = CH * MUL_DIGIT;
  localparam int AW   = OPW + BW;
  localparam int PW   = 2 * OPW;
  localparam int CNTW = (CH > 1) ? $clog2(CH) : 1;

  logic [OPW-1:0]           amag_r, amag_nxt;
  logic [BW-1:0]            bmag_r, bmag_nxt;
  logic                     neg_r, neg_nxt;
  logic [AW-1:0]            acc_r, acc_nxt;
  logic [CNTW-1:0]          cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [OPW+MUL_DIGIT-1:0] part;
  logic [OPW-1:0]           amag_in, bmag_in;
  logic [PW-1:0]            mag;

  assign amag_in = a_i[OPW-1] ? (~a_i + 1'b1) : a_i;
  assign bmag_in = b_i[OPW-1] ? (~b_i + 1'b1) : b_i;
  assign part    = amag_r * bmag_r[BW-1 -: MUL_DIGIT];
  assign mag     = acc_r[PW-1:0];

  always_comb begin
    amag_nxt = amag_r;
    bmag_nxt = bmag_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      amag_nxt = amag_in;
      bmag_nxt = {{(BW-OPW){1'b0}}, bmag_in};
      neg_nxt  = a_i[OPW-1] ^ b_i[OPW-1];
      acc_nxt  = '0;
      cnt_nxt  = CNTW'(CH - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt  = (acc_r << MUL_DIGIT) + AW'(part);
      bmag_nxt = bmag_r << MUL_DIGIT;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    amag_r <= amag_nxt;
    bmag_r <= bmag_nxt;
    neg_r  <= neg_nxt;
    acc_r  <= acc_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign prod = neg_r ? (~mag + 1'b1) : mag;

endmodule
`default_nettype wire

>>> rtl/core/pipb_dp.sv
// datapath: configuration, ring registers, edge operands, products and tests
`default_nettype none
module pipb_dp #(
  parameter int COORD_WIDTH = 32,
  parameter int CFG_WIDTH   = 32,
  parameter int OPW         = 67
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pipb_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]               cfg_wdata,
  input  logic signed [COORD_WIDTH-1:0]      vertex_x,
  input  logic signed [COORD_WIDTH-1:0]      vertex_y,
  input  pipb_pkg::pipb_cmd_t                cmd,
  output pipb_pkg::pipb_sts_t                sts
);
  import pipb_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int D   = CW + 1;
  localparam int PW  = 2 * OPW;
  localparam int BBW = ((CW > TOL_WIDTH) ? CW : TOL_WIDTH) + 2;

  logic signed [CW-1:0]   qx_r, qy_r;
  logic [TOL_WIDTH-1:0]   tol_r;
  logic signed [CW-1:0]   fx_r, fy_r, px_r, py_r, vx_r, vy_r;
  logic signed [CW-1:0]   ax_r, ay_r, bx_r, by_r;
  logic signed [OPW-1:0]  e2_r, len2_r, dot_r, cr_r, dist_r;
  logic signed [PW-1:0]   csq_r, elen_r;
  logic                   parity_r, bnd_r;

  logic signed [D-1:0]    abx, aby, apx, apy, bpx, bpy;
  logic signed [OPW-1:0]  op_a, op_b, prod_lo;
  logic [PW-1:0]          prod;
  logic                   mul_done;
  logic signed [BBW-1:0]  lo_x, hi_x, lo_y, hi_y, qx_e, qy_e, tol_e;
  logic                   bbox_ok, straddle, crosses;

  function automatic logic signed [OPW-1:0] ext_d(input logic signed [D-1:0] v);
    ext_d = {{(OPW-D){v[D-1]}}, v};
  endfunction

  function automatic logic signed [BBW-1:0] ext_b(input logic signed [CW-1:0] v);
    ext_b = {{(BBW-CW){v[CW-1]}}, v};
  endfunction

  assign abx = {bx_r[CW-1], bx_r} - {ax_r[CW-1], ax_r};
  assign aby = {by_r[CW-1], by_r} - {ay_r[CW-1], ay_r};
  assign apx = {qx_r[CW-1], qx_r} - {ax_r[CW-1], ax_r};
  assign apy = {qy_r[CW-1], qy_r} - {ay_r[CW-1], ay_r};
  assign bpx = {qx_r[CW-1], qx_r} - {bx_r[CW-1], bx_r};
  assign bpy = {qy_r[CW-1], qy_r} - {by_r[CW-1], by_r};

  always_comb begin
    op_a = ext_d(abx);
    op_b = ext_d(abx);
    case (cmd.mop)
      MOP_E2: begin
        op_a = {{(OPW-TOL_WIDTH){1'b0}}, tol_r};
        op_b = {{(OPW-TOL_WIDTH){1'b0}}, tol_r};
      end
      MOP_LEN_A: begin
        op_a = ext_d(abx);
        op_b = ext_d(abx);
      end
      MOP_LEN_B: begin
        op_a = ext_d(aby);
        op_b = ext_d(aby);
      end
      MOP_DOT_A: begin
        op_a = ext_d(apx);
        op_b = ext_d(abx);
      end
      MOP_DOT_B: begin
        op_a = ext_d(apy);
        op_b = ext_d(aby);
      end
      MOP_CR_A: begin
        op_a = ext_d(abx);
        op_b = ext_d(apy);
      end
      MOP_CR_B: begin
        op_a = ext_d(aby);
        op_b = ext_d(apx);
      end
      MOP_DA_A: begin
        op_a = ext_d(apx);
        op_b = ext_d(apx);
      end
      MOP_DA_B: begin
        op_a = ext_d(apy);
        op_b = ext_d(apy);
      end
      MOP_DB_A: begin
        op_a = ext_d(bpx);
        op_b = ext_d(bpx);
      end
      MOP_DB_B: begin
        op_a = ext_d(bpy);
        op_b = ext_d(bpy);
      end
      MOP_CSQ: begin
        op_a = cr_r;
        op_b = cr_r;
      end
      MOP_ELEN: begin
        op_a = e2_r;
        op_b = len2_r;
      end
      default: begin
        op_a = ext_d(abx);
        op_b = ext_d(abx);
      end
    endcase
  end

  pipb_mul #(.OPW(OPW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a_i   (op_a),
    .b_i   (op_b),
    .done  (mul_done),
    .prod  (prod)
  );

  assign prod_lo = prod[OPW-1:0];

  // tolerance-grown bounding box of the current edge
  assign qx_e  = ext_b(qx_r);
  assign qy_e  = ext_b(qy_r);
  assign tol_e = {{(BBW-TOL_WIDTH){1'b0}}, tol_r};
  assign lo_x  = ((ax_r < bx_r) ? ext_b(ax_r) : ext_b(bx_r)) - tol_e;
  assign hi_x  = ((ax_r > bx_r) ? ext_b(ax_r) : ext_b(bx_r)) + tol_e;
  assign lo_y  = ((ay_r < by_r) ? ext_b(ay_r) : ext_b(by_r)) - tol_e;
  assign hi_y  = ((ay_r > by_r) ? ext_b(ay_r) : ext_b(by_r)) + tol_e;
  assign bbox_ok = !(qx_e < lo_x) && !(qx_e > hi_x) && !(qy_e < lo_y) && !(qy_e > hi_y);

  assign straddle = (ay_r > qy_r) != (by_r > qy_r);
  assign crosses  = (aby > 0) ? (cr_r > 0) : (cr_r < 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r  <= '0;
      qy_r  <= '0;
      tol_r <= TOL_WIDTH'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUERY_X:   qx_r  <= cfg_wdata[CW-1:0];
        CFG_QUERY_Y:   qy_r  <= cfg_wdata[CW-1:0];
        CFG_TOLERANCE: tol_r <= cfg_wdata[TOL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r     <= '0;
      fy_r     <= '0;
      px_r     <= '0;
      py_r     <= '0;
      parity_r <= 1'b0;
      bnd_r    <= 1'b0;
    end else begin
      if (cmd.set_first) begin
        fx_r <= vertex_x;
        fy_r <= vertex_y;
      end
      if (cmd.set_prev) begin
        px_r <= vx_r;
        py_r <= vy_r;
      end
      if (cmd.edge_done) begin
        bnd_r    <= bnd_r | (bbox_ok & (cmd.use_perp ? sts.near_perp : sts.near_pt));
        parity_r <= parity_r ^ (straddle & crosses);
      end
      if (cmd.clear_ring) begin
        fx_r     <= '0;
        fy_r     <= '0;
        px_r     <= '0;
        py_r     <= '0;
        parity_r <= 1'b0;
        bnd_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_vertex) begin
      vx_r <= vertex_x;
      vy_r <= vertex_y;
    end
    if (cmd.load_ab) begin
      case (cmd.ab_sel)
        AB_FIRST_VTX: begin
          ax_r <= fx_r; ay_r <= fy_r; bx_r <= vx_r; by_r <= vy_r;
        end
        AB_PREV_VTX: begin
          ax_r <= px_r; ay_r <= py_r; bx_r <= vx_r; by_r <= vy_r;
        end
        AB_PREV_FIRST: begin
          ax_r <= px_r; ay_r <= py_r; bx_r <= fx_r; by_r <= fy_r;
        end
        AB_VTX_FIRST: begin
          ax_r <= vx_r; ay_r <= vy_r; bx_r <= fx_r; by_r <= fy_r;
        end
        default: begin
          ax_r <= fx_r; ay_r <= fy_r; bx_r <= vx_r; by_r <= vy_r;
        end
      endcase
    end
    if (mul_done) begin
      case (cmd.mop)
        MOP_E2:    e2_r   <= prod_lo;
        MOP_LEN_A: len2_r <= prod_lo;
        MOP_LEN_B: len2_r <= len2_r + prod_lo;
        MOP_DOT_A: dot_r  <= prod_lo;
        MOP_DOT_B: dot_r  <= dot_r + prod_lo;
        MOP_CR_A:  cr_r   <= prod_lo;
        MOP_CR_B:  cr_r   <= cr_r - prod_lo;
        MOP_DA_A:  dist_r <= prod_lo;
        MOP_DA_B:  dist_r <= dist_r + prod_lo;
        MOP_DB_A:  dist_r <= prod_lo;
        MOP_DB_B:  dist_r <= dist_r + prod_lo;
        MOP_CSQ:   csq_r  <= prod;
        MOP_ELEN:  elen_r <= prod;
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.mul_done  = mul_done;
    sts.len_zero  = (len2_r == '0);
    sts.dot_pos   = (dot_r > 0);
    sts.far_end   = (len2_r <= dot_r);
    sts.near_pt   = (dist_r <= e2_r);
    sts.near_dup  = (len2_r <= e2_r);
    sts.near_perp = (csq_r <= elen_r);
    sts.parity    = parity_r;
    sts.boundary  = bnd_r;
  end

endmodule
`default_nettype wire

>>> rtl/core/pipb_ctl.sv
// controller: per-item sequencing of duplicate check, edges and result
`default_nettype none
module pipb_ctl #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_last,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_location,
  output logic [COUNT_WIDTH-1:0]     out_count,
  output pipb_pkg::pipb_cmd_t        cmd,
  input  pipb_pkg::pipb_sts_t        sts
);
  import pipb_pkg::*;

  ctl_state_t             state_r, state_nxt;
  mop_t                   mop_r, mop_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] seen_r, seen_nxt;
  logic                   last_r, last_nxt, had_r, had_nxt, dup_r, dup_nxt;
  logic                   need_dup_r, need_dup_nxt, need_e1_r, need_e1_nxt;
  logic                   need_e2_r, need_e2_nxt, perp_r, perp_nxt;
  logic                   ov_r, ov_nxt;
  logic [1:0]             loc_r, loc_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] total, eff;
  logic                   accept, dup_check;
  logic [1:0]             loc_calc;

  assign accept    = in_valid && in_ready;
  assign total     = (seen_r == '1) ? seen_r : seen_r + 1'b1;
  assign eff       = dup_r ? total - 1'b1 : total;
  assign dup_check = in_last && (total > COUNT_WIDTH'(2));

  always_comb begin
    if (eff < COUNT_WIDTH'(3)) loc_calc = LOC_OUTSIDE;
    else if (sts.boundary)     loc_calc = LOC_BOUNDARY;
    else if (sts.parity)       loc_calc = LOC_INSIDE;
    else                       loc_calc = LOC_OUTSIDE;
  end

  always_comb begin
    state_nxt    = state_r;
    mop_nxt      = mop_r;
    phase_nxt    = phase_r;
    seen_nxt     = seen_r;
    last_nxt     = last_r;
    had_nxt      = had_r;
    dup_nxt      = dup_r;
    need_dup_nxt = need_dup_r;
    need_e1_nxt  = need_e1_r;
    need_e2_nxt  = need_e2_r;
    perp_nxt     = perp_r;
    ov_nxt       = ov_r && !out_ready;
    loc_nxt      = loc_r;
    cnt_nxt      = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt     = in_last;
          had_nxt      = (seen_r != '0);
          dup_nxt      = 1'b0;
          need_dup_nxt = dup_check;
          need_e1_nxt  = (seen_r != '0) && !dup_check;
          need_e2_nxt  = in_last && (seen_r != '0) && !dup_check;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        mop_nxt = MOP_E2;
        if (need_dup_r) begin
          need_dup_nxt = 1'b0;
          phase_nxt    = PH_DUP;
          state_nxt    = S_ISSUE;
        end else if (need_e1_r) begin
          need_e1_nxt = 1'b0;
          phase_nxt   = PH_EDGE;
          state_nxt   = S_ISSUE;
        end else if (need_e2_r) begin
          need_e2_nxt = 1'b0;
          phase_nxt   = PH_EDGE;
          state_nxt   = S_ISSUE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_ISSUE: state_nxt = S_MUL;
      S_MUL: begin
        if (sts.mul_done) begin
          state_nxt = S_ISSUE;
          case (mop_r)
            MOP_E2:    mop_nxt = MOP_LEN_A;
            MOP_LEN_A: mop_nxt = MOP_LEN_B;
            MOP_LEN_B: begin
              if (phase_r == PH_DUP) state_nxt = S_DUP_EVAL;
              else mop_nxt = MOP_DOT_A;
            end
            MOP_DOT_A: mop_nxt = MOP_DOT_B;
            MOP_DOT_B: mop_nxt = MOP_CR_A;
            MOP_CR_A:  mop_nxt = MOP_CR_B;
            MOP_CR_B: begin
              if (sts.len_zero || !sts.dot_pos) mop_nxt = MOP_DA_A;
              else if (sts.far_end)             mop_nxt = MOP_DB_A;
              else                              mop_nxt = MOP_CSQ;
            end
            MOP_DA_A:  mop_nxt = MOP_DA_B;
            MOP_DB_A:  mop_nxt = MOP_DB_B;
            MOP_CSQ:   mop_nxt = MOP_ELEN;
            MOP_DA_B, MOP_DB_B: begin
              perp_nxt  = 1'b0;
              state_nxt = S_EDGE_EVAL;
            end
            MOP_ELEN: begin
              perp_nxt  = 1'b1;
              state_nxt = S_EDGE_EVAL;
            end
            default: state_nxt = S_DISPATCH;
          endcase
        end
      end
      S_DUP_EVAL: begin
        dup_nxt     = sts.near_dup;
        need_e1_nxt = had_r && !sts.near_dup;
        need_e2_nxt = last_r && (sts.near_dup || had_r);
        state_nxt   = S_DISPATCH;
      end
      S_EDGE_EVAL: state_nxt = S_DISPATCH;
      S_FINISH: begin
        if (!last_r) begin
          seen_nxt  = total;
          state_nxt = S_IDLE;
        end else if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          loc_nxt   = loc_calc;
          cnt_nxt   = eff;
          seen_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.mop         = mop_r;
    cmd.use_perp    = perp_r;
    cmd.take_vertex = accept;
    cmd.set_first   = accept && (seen_r == '0);
    in_ready        = (state_r == S_IDLE);
    case (state_r)
      S_DISPATCH: begin
        cmd.load_ab = need_dup_r || need_e1_r || need_e2_r;
        if (need_dup_r)     cmd.ab_sel = AB_FIRST_VTX;
        else if (need_e1_r) cmd.ab_sel = AB_PREV_VTX;
        else if (dup_r)     cmd.ab_sel = AB_PREV_FIRST;
        else                cmd.ab_sel = AB_VTX_FIRST;
      end
      S_ISSUE:     cmd.mul_start = 1'b1;
      S_EDGE_EVAL: cmd.edge_done = 1'b1;
      S_FINISH: begin
        cmd.set_prev   = !last_r;
        cmd.clear_ring = last_r && (!ov_r || out_ready);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      seen_r     <= '0;
      need_dup_r <= 1'b0;
      need_e1_r  <= 1'b0;
      need_e2_r  <= 1'b0;
      dup_r      <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      seen_r     <= seen_nxt;
      need_dup_r <= need_dup_nxt;
      need_e1_r  <= need_e1_nxt;
      need_e2_r  <= need_e2_nxt;
      dup_r      <= dup_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mop_r   <= mop_nxt;
    phase_r <= phase_nxt;
    last_r  <= last_nxt;
    had_r   <= had_nxt;
    perp_r  <= perp_nxt;
    loc_r   <= loc_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign out_valid    = ov_r;
  assign out_location = loc_r;
  assign out_count    = cnt_r;

endmodule
`default_nettype wire

>>> rtl/core/point_in_polygon_boundary.sv
// top level: point-in-polygon classifier with boundary tolerance
//
//   channel  direction  payload
//   in_ch    in         vertex_x, vertex_y, is_last
//   out_ch   out        location, effective_count (one item per closed ring)
//   cfg_*    in         query_x (0), query_y (1), tolerance (2)
//
// one vertex is worked on at a time; each edge test costs 9 products on one shared
// multiplier, each product formed over CH = ceil(OPW/16) digits of its multiplier
// operand. a closing vertex of a ring that holds more than two vertices first gets a
// duplicate check (3 products); its ring is then closed by an edge back to the first
// vertex. rst_n is synchronous and clears the ring.
// a finished result waits in the output register while the next vertex is taken.
`default_nettype none
module point_in_polygon_boundary #(
  parameter int  COORD_WIDTH = 32,
  parameter int  COUNT_WIDTH = 16,
  localparam int CFG_WIDTH   = (COORD_WIDTH > pipb_pkg::TOL_WIDTH) ?
                               COORD_WIDTH : pipb_pkg::TOL_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pipb_in_if.sink                            in_ch,
  pipb_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [pipb_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]               cfg_wdata
);
  import pipb_pkg::*;

  localparam int OPW = (2 * COORD_WIDTH + 3 > 2 * TOL_WIDTH + 1) ?
                       2 * COORD_WIDTH + 3 : 2 * TOL_WIDTH + 1;

  pipb_cmd_t cmd;
  pipb_sts_t sts;

  pipb_ctl #(.COUNT_WIDTH(COUNT_WIDTH)) u_ctl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_last      (in_ch.is_last),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_location (out_ch.location),
    .out_count    (out_ch.effective_count),
    .cmd          (cmd),
    .sts          (sts)
  );

  pipb_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .CFG_WIDTH   (CFG_WIDTH),
    .OPW         (OPW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .vertex_x  (in_ch.vertex_x),
    .vertex_y  (in_ch.vertex_y),
    .cmd       (cmd),
    .sts       (sts)
  );

  a_short_ring_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.effective_count < COUNT_WIDTH'(3))
      |-> out_ch.location == LOC_OUTSIDE)
    else $error("short ring not classified outside");

  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("new item taken while previous one in work");

  a_reset_no_result: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result pending after reset");

  a_no_start_while_edge: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !cmd.edge_done && !cmd.clear_ring)
    else $error("multiply issued during ring update");

endmodule
`default_nettype wire

>>> test/point_in_polygon_boundary_test.sv
// self-checking testbench for the point-in-polygon boundary classifier
`timescale 1ns / 100ps
module point_in_polygon_boundary_test;
  import pipb_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef struct {
    logic [1:0]  location;
    logic [15:0] count;
  } ring_result_t;

  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint TOL_MAX   = 64'sd2147483647;
  localparam int     COUNT_MAX = 65535;
  localparam int     QUIET_LIMIT = 5000;

  class ring_scoreboard;
    longint       qx, qy, tol;
    longint       first_x, first_y, prev_x, prev_y;
    int           seen;
    bit           parity, hit;
    ring_result_t pending_rings[$];
    int           errors;

    function new();
      qx = 0; qy = 0; tol = 1; errors = 0;
      clear_ring();
    endfunction

    function void clear_ring();
      first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
      seen = 0; parity = 0; hit = 0;
    endfunction

    function wide_t sq2(longint a, longint b);
      wide_t wa, wb;
      wa = a; wb = b;
      return wa * wa + wb * wb;
    endfunction

    function bit near_edge(longint ax, longint ay, longint bx, longint by);
      wide_t len2, dot, e2, w_abx, w_aby, w_apx, w_apy, cr, et;
      longint abx, aby, apx, apy;
      abx = bx - ax; aby = by - ay; apx = qx - ax; apy = qy - ay;
      et = tol; e2 = et * et;
      if (qx < ((ax < bx) ? ax : bx) - tol || qx > ((ax > bx) ? ax : bx) + tol) return 0;
      if (qy < ((ay < by) ? ay : by) - tol || qy > ((ay > by) ? ay : by) + tol) return 0;
      w_abx = abx; w_aby = aby; w_apx = apx; w_apy = apy;
      len2 = sq2(abx, aby);
      dot = w_apx * w_abx + w_apy * w_aby;
      if (len2 == 0 || dot <= 0) return sq2(apx, apy) <= e2;
      if (len2 <= dot) return sq2(qx - bx, qy - by) <= e2;
      cr = w_abx * w_apy - w_aby * w_apx;
      return cr * cr <= e2 * len2;
    endfunction

    function void add_edge(longint ax, longint ay, longint bx, longint by);
      wide_t lhs, rhs, t0, t1;
      longint dy;
      bit crosses;
      if (near_edge(ax, ay, bx, by)) hit = 1;
      if ((ay > qy) != (by > qy)) begin
        dy = by - ay;
        t0 = qx - ax; t1 = dy; lhs = t0 * t1;
        t0 = bx - ax; t1 = qy - ay; rhs = t0 * t1;
        crosses = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
        if (crosses) parity = !parity;
      end
    endfunction

    function void take_vertex(logic signed [31:0] x, logic signed [31:0] y, logic last);
      longint vx, vy, tsq;
      wide_t et;
      int total, eff;
      bit had, dup;
      ring_result_t r;
      vx = x; vy = y;
      had = (seen != 0);
      total = (seen < COUNT_MAX) ? seen + 1 : COUNT_MAX;
      dup = 0;
      if (!had) begin
        first_x = vx; first_y = vy;
      end
      et = tol;
      if (last && total > 2 && sq2(first_x - vx, first_y - vy) <= et * et) dup = 1;
      if (had && !dup) add_edge(prev_x, prev_y, vx, vy);
      if (!last) begin
        prev_x = vx; prev_y = vy; seen = total;
        return;
      end
      if (dup) begin
        add_edge(prev_x, prev_y, first_x, first_y);
        eff = total - 1;
      end else begin
        if (had) add_edge(vx, vy, first_x, first_y);
        eff = total;
      end
      if (eff < 3) r.location = LOC_OUTSIDE;
      else if (hit) r.location = LOC_BOUNDARY;
      else r.location = parity ? LOC_INSIDE : LOC_OUTSIDE;
      r.count = eff[15:0];
      pending_rings.push_back(r);
      clear_ring();
    endfunction

    function void check_result(logic [1:0] location, logic [15:0] count);
      ring_result_t r;
      if (pending_rings.size() == 0) begin
        $error("unexpected result location=%0d effective_count=%0d", location, count);
        errors++;
        return;
      end
      r = pending_rings.pop_front();
      if (location !== r.location) begin
        $error("location expected %0d actual %0d", r.location, location);
        errors++;
      end
      if (count !== r.count) begin
        $error("effective_count expected %0d actual %0d", r.count, count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  pipb_in_if #(.COORD_WIDTH(32)) in_if ();
  pipb_out_if #(.COUNT_WIDTH(16)) out_if ();

  ring_scoreboard sb = new();
  bit no_idle;
  int out_stall;
  int quiet;
  int items_sent;

  point_in_polygon_boundary #(.COORD_WIDTH(32), .COUNT_WIDTH(16)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
      quiet = 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.location, out_if.effective_count);
        out_stall = no_idle ? 0 : $urandom_range(0, 15);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_if.ready <= (out_stall == 0);
      if (quiet >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_vertex(longint x, longint y, bit last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.vertex_x <= x[31:0];
    in_if.vertex_y <= y[31:0];
    in_if.is_last <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.take_vertex(x[31:0], y[31:0], last);
    items_sent++;
  endtask

  task automatic set_query(longint x, longint y, logic [31:0] tol_word);
    cfg_we <= 1'b1;
    cfg_index <= CFG_QUERY_X;
    cfg_wdata <= x[31:0];
    @(posedge clk);
    cfg_index <= CFG_QUERY_Y;
    cfg_wdata <= y[31:0];
    @(posedge clk);
    cfg_index <= CFG_TOLERANCE;
    cfg_wdata <= tol_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.qx = longint'(int'(x));
    sb.qy = longint'(int'(y));
    sb.tol = longint'(tol_word[30:0]);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_rings.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic longint pick_coord(longint base, longint span);
    longint v;
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    v = base + longint'($urandom_range(0, 32'(2 * span))) - span;
    return longint'(int'(v));
  endfunction

  task automatic send_ring();
    longint xs[$], ys[$];
    longint span, jit;
    int kind, n;
    kind = $urandom_range(0, 9);
    span = longint'(1) << $urandom_range(4, 30);
    n = $urandom_range(1, 8);
    if (kind == 0) begin
      repeat (n) begin
        xs.push_back(longint'(int'($urandom)));
        ys.push_back(longint'(int'($urandom)));
      end
    end else begin
      if (kind <= 3 && n < 3) n = 3;
      repeat (n) begin
        xs.push_back(pick_coord(sb.qx, span));
        ys.push_back(pick_coord(sb.qy, span));
      end
      if (kind == 4) begin
        xs[$urandom_range(0, n - 1)] = sb.qx;
        ys[$urandom_range(0, n - 1)] = sb.qy;
      end
      if (kind <= 3) begin
        jit = sb.tol / 2;
        if (jit > (longint'(1) << 30)) jit = longint'(1) << 30;
        xs.push_back(longint'(int'(xs[0] + longint'($urandom_range(0, 32'(jit))))));
        ys.push_back(longint'(int'(ys[0] - longint'($urandom_range(0, 32'(jit))))));
      end
    end
    foreach (xs[i]) send_vertex(xs[i], ys[i], i == xs.size() - 1);
  endtask

  initial begin
    longint u;
    logic [31:0] tol_word;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.vertex_x = '0;
    in_if.vertex_y = '0;
    in_if.is_last = 1'b0;
    out_if.ready = 1'b0;
    no_idle = 0;
    items_sent = 0;
    u = 65536;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone vertex, two-vertex ring, inside triangle, closing duplicate
    send_vertex(5 * u, 5 * u, 1);
    send_vertex(-u, -u, 0);
    send_vertex(u, u, 1);
    send_vertex(-10 * u, -10 * u, 0);
    send_vertex(10 * u, -10 * u, 0);
    send_vertex(0, 10 * u, 1);
    send_vertex(-10 * u, -10 * u, 0);
    send_vertex(10 * u, -10 * u, 0);
    send_vertex(0, 10 * u, 0);
    send_vertex(-10 * u, -10 * u, 1);
    // query on an edge, then a triangle at the coordinate extremes
    send_vertex(0, -u, 0);
    send_vertex(4 * u, -u, 0);
    send_vertex(4 * u, 4 * u, 0);
    send_vertex(0, 4 * u, 1);
    send_vertex(COORD_MIN, COORD_MIN, 0);
    send_vertex(COORD_MAX, COORD_MIN, 0);
    send_vertex(0, COORD_MAX, 1);
    // outside triangle, repeated vertex
    send_vertex(20 * u, 20 * u, 0);
    send_vertex(30 * u, 20 * u, 0);
    send_vertex(30 * u, 20 * u, 0);
    send_vertex(25 * u, 30 * u, 1);
    drain();

    for (int p = 0; p < 12; p++) begin
      no_idle = (p % 4 == 3);
      tol_word = {$urandom_range(0, 1) == 1, 31'd0};
      case (p)
        0: set_query(0, 0, tol_word);
        1: set_query(COORD_MAX, COORD_MAX, tol_word | TOL_MAX[31:0]);
        2: set_query(COORD_MIN, COORD_MIN, tol_word | 32'd1);
        default: begin
          case ($urandom_range(0, 2))
            0: tol_word[30:0] = 31'd0;
            1: tol_word[30:0] = 31'($urandom_range(0, 262144));
            default: tol_word[30:0] = 31'($urandom);
          endcase
          if ($urandom_range(0, 3) == 0)
            set_query(longint'(int'($urandom)), longint'(int'($urandom)), tol_word);
          else
            set_query(longint'($urandom_range(0, 32'h7fffffff)) - 64'sd1073741824,
                      longint'($urandom_range(0, 32'h7fffffff)) - 64'sd1073741824,
                      tol_word);
        end
      endcase
      while (items_sent < (p + 1) * 160 + 21) send_ring();
      drain();
    end

    if (sb.pending_rings.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_rings.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> point_in_polygon_boundary.f
rtl/core/pipb_pkg.sv
rtl/core/pipb_if.sv
rtl/core/pipb_mul.sv
rtl/core/pipb_dp.sv
rtl/core/pipb_ctl.sv
rtl/core/point_in_polygon_boundary.sv
test/point_in_polygon_boundary_test.sv
